// ===== rtl/alp_pkg.sv =====
// shared types, constants and character helpers for the access log line parser
package alp_pkg;

   localparam int MAX_LINE = 8192;
   localparam int LEN_W    = $clog2(MAX_LINE);
   localparam int SIZE_W   = 48;
   localparam int SUM_W    = 63;
   localparam int PROD_W   = SIZE_W + 4;

   localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(MAX_LINE - 1);
   localparam logic [SIZE_W-1:0] SIZE_MAX  = {SIZE_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_DIG0   = 8'h30;
   localparam logic [7:0] CH_DIG9   = 8'h39;
   localparam logic [7:0] CH_LBRACK = 8'h5b;

   typedef enum logic [3:0] {
      PH_ADDR, PH_IDENT, PH_BRACKET, PH_OPENQ, PH_METHOD, PH_URI, PH_CLOSEQ,
      PH_STATUS_SP, PH_STATUS, PH_SIZE_SP, PH_REFQ, PH_REFERER, PH_DONE, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      NUM_WS, NUM_SIGN, NUM_DIGITS, NUM_DONE
   } num_type;

   // control from the line state machine to the size parser
   typedef struct packed {
      logic step;
      logic feed;
      logic dash;
      logic clear;
   } size_ctl_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[CH_DIG0:CH_DIG9]});
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

endpackage

// ===== rtl/alp_size.sv =====
// decimal size field parser with sign, saturation and per-line clear
module alp_size import alp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  size_ctl_type      ctl,
   input  logic [7:0]        data_byte,
   output logic [SIZE_W-1:0] size_value
);

   num_type             num_ff, num_in;
   logic [SIZE_W-1:0]   acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod;

   // acc * 10 + digit, as two shifts and adds
   assign prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                 + {{(PROD_W-4){1'b0}}, data_byte[3:0]};

   always_comb begin
      num_in = num_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      if (ctl.clear) begin
         num_in = NUM_WS;
         acc_in = '0;
         neg_in = 1'b0;
      end else if (ctl.dash) begin
         num_in = NUM_DONE;
         acc_in = '0;
      end else if (ctl.feed && num_ff != NUM_DONE) begin
         if (is_digit(data_byte)) begin
            acc_in = (prod[PROD_W-1:SIZE_W] != '0) ? SIZE_MAX : prod[SIZE_W-1:0];
            num_in = NUM_DIGITS;
         end else if (num_ff == NUM_WS && is_ws(data_byte)) begin
            num_in = NUM_WS;
         end else if (num_ff == NUM_WS && (data_byte == CH_PLUS || data_byte == CH_DASH)) begin
            neg_in = (data_byte == CH_DASH);
            num_in = NUM_SIGN;
         end else begin
            num_in = NUM_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= NUM_WS;
         acc_ff <= '0;
         neg_ff <= 1'b0;
      end else if (ctl.step) begin
         num_ff <= num_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
      end
   end

   assign size_value = neg_ff ? '0 : acc_ff;

endmodule

// ===== rtl/access_log_line_parser.sv =====
// top level of the access log line parser: byte register, line state machine, result register
//
// usage
//   req_ channel: one beat per byte of log text (req_data_byte) with req_file_last
//   marking the final byte of a file. rsp_ channel: one beat per input byte, with
//   the byte echoed, uri and referer tags, and at the line's last byte the line
//   status, the parsed response size and the running traffic total.
//   a line ends on newline, on a byte marked file_last, or after 8191 bytes.
//   an accepted byte is parsed while it sits in the byte register, and its result
//   beat is captured in the result register when that register can move.
//   throughput: one byte per clock unless rsp_stall holds a waiting result; the parse
//   state and the size multiply-add by ten are combinational from byte to result register.
//   stall: when rsp_stall holds a waiting result, an empty byte register still takes
//   one more byte, then req_stall rises until the result moves.
//   reset: synchronous; clears the parse state, the traffic total and both
//   valid flags. no clearing pass is needed.
module access_log_line_parser import alp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_file_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_echo_byte,
   output logic              rsp_is_uri,
   output logic              rsp_is_referer,
   output logic              rsp_line_end,
   output logic              rsp_line_ok,
   output logic [SIZE_W-1:0] rsp_response_size,
   output logic [SUM_W-1:0]  rsp_traffic_total
);

   // byte register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              out_uri_ff, out_ref_ff, out_end_ff, out_ok_ff;
   logic [SIZE_W-1:0] out_size_ff;
   logic [SUM_W-1:0]  out_total_ff;

   // line state
   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic              advance, work;
   logic              tag_uri, tag_ref, feed, dash;
   logic              line_end, line_ok;
   logic [SIZE_W-1:0] size_value, size_out;
   logic [SUM_W:0]    sum_wide;
   size_ctl_type      size_ctl;

   // result register can move when empty or when its beat is taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign work      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_file_last;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_byte_ff == CH_NUL) begin
         if (phase_ff != PH_DONE) phase_in = PH_FAIL;
      end else begin
         case (phase_ff)
            PH_ADDR:      if (in_byte_ff == CH_SPACE) phase_in = PH_IDENT;
            PH_IDENT:     if (in_byte_ff == CH_SPACE) phase_in = PH_BRACKET;
            PH_BRACKET:   if (in_byte_ff == CH_LBRACK) phase_in = PH_OPENQ;
            PH_OPENQ:     if (in_byte_ff == CH_QUOTE) phase_in = PH_METHOD;
            PH_METHOD:    if (in_byte_ff == CH_SPACE) phase_in = PH_URI;
            PH_URI:       if (in_byte_ff == CH_SPACE) phase_in = PH_CLOSEQ;
            PH_CLOSEQ:    if (in_byte_ff == CH_QUOTE) phase_in = PH_STATUS_SP;
            PH_STATUS_SP: begin
               if (in_byte_ff != CH_SPACE)
                  phase_in = is_digit(in_byte_ff) ? PH_STATUS : PH_FAIL;
            end
            PH_STATUS:    if (in_byte_ff == CH_SPACE) phase_in = PH_SIZE_SP;
            PH_SIZE_SP: begin
               if (in_byte_ff == CH_QUOTE) phase_in = PH_REFERER;
               else if (in_byte_ff != CH_SPACE) phase_in = PH_REFQ;
            end
            PH_REFQ:      if (in_byte_ff == CH_QUOTE) phase_in = PH_REFERER;
            PH_REFERER:   if (in_byte_ff == CH_QUOTE) phase_in = PH_DONE;
            default:      phase_in = phase_ff;
         endcase
      end
   end

   // per-byte outputs of the state machine
   always_comb begin
      tag_uri = 1'b0;
      tag_ref = 1'b0;
      feed    = 1'b0;
      dash    = 1'b0;
      if (in_byte_ff != CH_NUL) begin
         case (phase_ff)
            PH_URI:     tag_uri = (in_byte_ff != CH_SPACE);
            PH_REFERER: tag_ref = (in_byte_ff != CH_QUOTE);
            PH_SIZE_SP: begin
               dash = (in_byte_ff == CH_DASH);
               feed = (in_byte_ff != CH_SPACE) && (in_byte_ff != CH_DASH);
            end
            PH_REFQ:    feed = 1'b1;
            default:    feed = 1'b0;
         endcase
      end
   end

   // line end and the totals
   assign len_in   = len_ff + LEN_W'(1);
   assign line_end = (in_byte_ff == CH_NL) || in_last_ff || (len_in >= LEN_LIMIT);
   assign line_ok  = line_end && (phase_in == PH_DONE);
   assign size_out = line_ok ? size_value : '0;
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W+1-SIZE_W){1'b0}}, size_out};
   assign sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   assign size_ctl.step  = work;
   assign size_ctl.feed  = feed;
   assign size_ctl.dash  = dash;
   assign size_ctl.clear = line_end;

   alp_size u_size (
      .clock      (clock),
      .reset      (reset),
      .ctl        (size_ctl),
      .data_byte  (in_byte_ff),
      .size_value (size_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ADDR;
         len_ff   <= '0;
         sum_ff   <= '0;
      end else if (work) begin
         phase_ff <= line_end ? PH_ADDR : phase_in;
         len_ff   <= line_end ? '0 : len_in;
         if (line_ok) sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         out_byte_ff  <= in_byte_ff;
         out_uri_ff   <= tag_uri;
         out_ref_ff   <= tag_ref;
         out_end_ff   <= line_end;
         out_ok_ff    <= line_ok;
         out_size_ff  <= size_out;
         out_total_ff <= !line_end ? '0 : (line_ok ? sum_in : sum_ff);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_echo_byte     = out_byte_ff;
   assign rsp_is_uri        = out_uri_ff;
   assign rsp_is_referer    = out_ref_ff;
   assign rsp_line_end      = out_end_ff;
   assign rsp_line_ok       = out_ok_ff;
   assign rsp_response_size = out_size_ff;
   assign rsp_traffic_total = out_total_ff;

   // a line status only on the beat that ends the line
   a_ok_at_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ok_ff |-> out_end_ff)
      else $error("line_ok without line_end");

   // a byte is never both uri and referer
   a_tags_apart: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_uri_ff && out_ref_ff))
      else $error("uri and referer tags together");

   // mid-line beats carry no size or total
   a_mid_line_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_end_ff |-> out_size_ff == '0 && out_total_ff == '0)
      else $error("size or total on a mid-line beat");

   // the line length never reaches the forced end
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff < LEN_LIMIT)
      else $error("line length overran");

   // traffic total never decreases between resets
   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> sum_ff >= $past(sum_ff))
      else $error("traffic total decreased");

endmodule
